// ----- rtl/core/sadc_pkg.sv -----
package sadc_pkg;

	localparam int NUM_DIGITS = 16;
	localparam int IDX_W      = $clog2(NUM_DIGITS);
	localparam int CHAR_W     = 6;
	localparam int MID_DEPTH  = 2;
	localparam int OUT_DEPTH  = 2;

	// item kinds
	localparam logic [1:0] KIND_LINE = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// control byte groups, bits 6..5
	localparam logic [1:0] GRP_TEST   = 2'd0;
	localparam logic [1:0] GRP_CURSOR = 2'd1;
	localparam logic [1:0] GRP_COUNT  = 2'd2;
	localparam logic [1:0] GRP_BRIGHT = 2'd3;

	localparam logic [CHAR_W-1:0] CH_COMMA   = 6'd44;
	localparam logic [CHAR_W-1:0] CH_DOT     = 6'd46;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 6'd32;
	localparam logic [CHAR_W-1:0] MARK_PLAIN = 6'd6;
	localparam logic [CHAR_W-1:0] MARK_NONE  = 6'd0;

	localparam logic [4:0] DIGITS_RESET = 5'd16;
	localparam logic [4:0] BRIGHT_RESET = 5'd31;

	typedef struct packed {
		logic [1:0]       kind;
		logic             reset_line;
		logic             clock_line;
		logic [7:0]       data_value;
		logic [IDX_W-1:0] digit_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0]       segments;
		logic [CHAR_W-1:0] dot_comma;
		logic [4:0]        brightness_level;
		logic [4:0]        digit_count_out;
		logic [IDX_W-1:0]  cursor;
		logic              byte_done;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LRESET,
		OP_EXEC
	} op_code_t;

	typedef struct packed {
		op_code_t         code;
		logic [7:0]       cmd;
		logic [IDX_W-1:0] idx;
	} op_t;

	localparam logic [15:0] SEG_TABLE [64] = '{
		16'h507F, 16'h44CF, 16'h153F, 16'h00F3, 16'h113F, 16'h40F3, 16'h40C3, 16'h04FB,
		16'h44CC, 16'h1133, 16'h007C, 16'h4AC0, 16'h00F0, 16'h82CC, 16'h88CC, 16'h00FF,
		16'h44C7, 16'h08FF, 16'h4CC7, 16'h44BB, 16'h1103, 16'h00FC, 16'h22C0, 16'h28CC,
		16'hAA00, 16'h9200, 16'h2233, 16'h00E1, 16'h8800, 16'h001E, 16'h2800, 16'h0030,
		16'h0000, 16'h8121, 16'h0180, 16'h553C, 16'h11BB, 16'h7799, 16'hC979, 16'h0200,
		16'h0A00, 16'hA000, 16'hFF00, 16'h5500, 16'h0000, 16'h4400, 16'h0000, 16'h2200,
		16'h22FF, 16'h1100, 16'h4477, 16'h443F, 16'h448C, 16'h44BB, 16'h44FB, 16'h000F,
		16'h44FF, 16'h44BF, 16'h0021, 16'h2001, 16'h4430, 16'h4430, 16'h0312, 16'h1407
	};

	// a few codes show as blank, the top codes shift down one
	function automatic logic [CHAR_W-1:0] remap_code(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c == 6'd27 || c == 6'd29 || c == 6'd30 || c == 6'd33) begin
			r = CH_SPACE;
		end else if (c >= 6'd57) begin
			r = c - 6'd1;
		end
		return r;
	endfunction

	function automatic logic [15:0] seg_lookup(input logic [CHAR_W-1:0] c);
		return SEG_TABLE[remap_code(c)];
	endfunction

endpackage

// ----- rtl/core/serial_16seg_alpha_display_controller_top.sv -----
// Flow: a transfer accepted into the op queue is executed by the back end into its state and s1
// registers, then pushed into the result queue, whose outputs show it with empty low.
// Throughput: one item per cycle while the result queue is not full; a full result queue stalls the back end.
// Reset (arst_n low, asynchronous): receiver, cursor, previous cursor cleared, digit count 16,
// brightness 31, every digit shows a space with no mark, both queues empty.
module serial_16seg_alpha_display_controller_top #(
	parameter int MID_DEPTH = sadc_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = sadc_pkg::OUT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sadc_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output sadc_pkg::out_item_t result
);

	localparam int OP_W  = $bits(sadc_pkg::op_t);
	localparam int RES_W = $bits(sadc_pkg::out_item_t);

	logic                accept;
	sadc_pkg::op_t       fr_op;
	logic [OP_W-1:0]     mid_rdata;
	sadc_pkg::op_t       bk_op;
	logic                mid_empty;
	logic                mid_pop;
	sadc_pkg::out_item_t bk_res;
	logic                res_push;
	logic                res_full;
	logic [RES_W-1:0]    out_rdata;

	// Front end: owns the serial receiver (clock edge detect, bit counter,
	// shift register) and turns every transfer into one op for the back end.
	assign accept = push && !full;

	sadc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.op     (fr_op)
	);

	// Op queue between front and back; its full flag is the input full.
	sadc_queue #(
		.WIDTH (OP_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (fr_op),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign bk_op = sadc_pkg::op_t'(mid_rdata);

	// Back end: cursor, settings and digit stores; reads the addressed digit
	// after the update and builds the result.
	sadc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (bk_op),
		.op_empty (mid_empty),
		.op_pop   (mid_pop),
		.res      (bk_res),
		.res_push (res_push),
		.res_full (res_full)
	);

	// Result queue: lets the back end keep going while a result waits.
	sadc_queue #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (bk_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign result = sadc_pkg::out_item_t'(out_rdata);

endmodule

// ----- rtl/core/sadc_queue.sv -----
module sadc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/core/sadc_front.sv -----
module sadc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  sadc_pkg::in_item_t item,
	output sadc_pkg::op_t      op
);

	localparam logic [2:0] LAST_BIT = 3'd7;

	logic       prev_clock_q;
	logic [2:0] bit_count_q;
	logic [7:0] shift_q;
	logic       prev_clock_d;
	logic [2:0] bit_count_d;
	logic [7:0] shift_d;
	logic [7:0] bit_v;

	always_comb begin
		op.code      = sadc_pkg::OP_NONE;
		op.cmd       = item.data_value;
		op.idx       = item.digit_index;
		prev_clock_d = prev_clock_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		bit_v        = shift_q | {7'd0, (item.data_value != 8'd0)};
		unique case (item.kind)
			sadc_pkg::KIND_LINE: begin
				if (!item.reset_line) begin
					prev_clock_d = item.clock_line;
					bit_count_d  = '0;
					shift_d      = '0;
					op.code      = sadc_pkg::OP_LRESET;
				end else begin
					// falling clock edge takes one bit
					if (prev_clock_q && !item.clock_line) begin
						if (bit_count_q == LAST_BIT) begin
							op.code     = sadc_pkg::OP_EXEC;
							op.cmd      = bit_v;
							bit_count_d = '0;
							shift_d     = '0;
						end else begin
							shift_d     = {bit_v[6:0], 1'b0};
							bit_count_d = bit_count_q + 3'd1;
						end
					end
					prev_clock_d = item.clock_line;
				end
			end
			sadc_pkg::KIND_BYTE: begin
				if (item.reset_line) begin
					op.code     = sadc_pkg::OP_EXEC;
					bit_count_d = '0;
					shift_d     = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clock_q <= 1'b0;
			bit_count_q  <= '0;
			shift_q      <= '0;
		end else if (accept) begin
			prev_clock_q <= prev_clock_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
		end
	end

endmodule

// ----- rtl/core/sadc_back.sv -----
module sadc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sadc_pkg::op_t       op,
	input  logic                op_empty,
	output logic                op_pop,
	output sadc_pkg::out_item_t res,
	output logic                res_push,
	input  logic                res_full
);

	localparam int IW = sadc_pkg::IDX_W;
	localparam int CW = sadc_pkg::CHAR_W;

	logic [CW-1:0] char_q [sadc_pkg::NUM_DIGITS];
	logic [CW-1:0] mark_q [sadc_pkg::NUM_DIGITS];
	logic [IW-1:0] wp_q;
	logic [IW-1:0] prev_q;
	logic [4:0]    du_q;
	logic [4:0]    bright_q;

	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          done_s1;

	logic          exec;
	logic          run;
	logic [7:0]    b;
	logic [CW-1:0] c;
	logic          char_we;
	logic          mark_we;
	logic [IW-1:0] mark_addr;
	logic [CW-1:0] mark_data;
	logic [IW-1:0] wp_d;
	logic [IW-1:0] prev_d;
	logic [4:0]    du_d;
	logic [4:0]    bright_d;

	assign res_push = v_s1 && !res_full;
	assign exec     = !op_empty && (!v_s1 || !res_full);
	assign op_pop   = exec;
	assign run      = exec && (op.code == sadc_pkg::OP_EXEC);
	assign b        = op.cmd;
	assign c        = b[CW-1:0];

	always_comb begin
		char_we   = 1'b0;
		mark_we   = 1'b0;
		mark_addr = wp_q;
		mark_data = sadc_pkg::MARK_PLAIN;
		wp_d      = wp_q;
		prev_d    = prev_q;
		du_d      = du_q;
		bright_d  = bright_q;
		if (exec && op.code == sadc_pkg::OP_LRESET) begin
			wp_d     = '0;
			prev_d   = '0;
			du_d     = sadc_pkg::DIGITS_RESET;
			bright_d = sadc_pkg::BRIGHT_RESET;
		end else if (run) begin
			if (!b[7]) begin
				if (c == sadc_pkg::CH_COMMA || c == sadc_pkg::CH_DOT) begin
					// punctuation marks the digit at the previous cursor (last written, or the cursor before a move)
					mark_we   = 1'b1;
					mark_addr = prev_q;
					mark_data = c;
				end else begin
					char_we = 1'b1;
					mark_we = 1'b1;
					prev_d  = wp_q;
					wp_d    = wp_q + 1'b1;
				end
			end else begin
				unique case (b[6:5])
					sadc_pkg::GRP_CURSOR: begin
						prev_d = wp_q;
						wp_d   = b[IW-1:0] + 1'b1;  // 15 wraps to 0
					end
					sadc_pkg::GRP_COUNT: begin
						du_d = (b[3:0] == 4'd0) ? sadc_pkg::DIGITS_RESET : {1'b0, b[3:0]};
					end
					sadc_pkg::GRP_BRIGHT: begin
						bright_d = b[4:0];
					end
					sadc_pkg::GRP_TEST: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sadc_pkg::NUM_DIGITS; i++) begin
				char_q[i] <= sadc_pkg::CH_SPACE;
				mark_q[i] <= sadc_pkg::MARK_NONE;
			end
			wp_q     <= '0;
			prev_q   <= '0;
			du_q     <= sadc_pkg::DIGITS_RESET;
			bright_q <= sadc_pkg::BRIGHT_RESET;
			v_s1     <= 1'b0;
		end else begin
			if (char_we) begin
				char_q[wp_q] <= c;
			end
			if (mark_we) begin
				mark_q[mark_addr] <= mark_data;
			end
			wp_q     <= wp_d;
			prev_q   <= prev_d;
			du_q     <= du_d;
			bright_q <= bright_d;
			if (exec) begin
				v_s1 <= 1'b1;
			end else if (res_push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			idx_s1  <= op.idx;
			done_s1 <= (op.code == sadc_pkg::OP_EXEC);
		end
	end

	// state registers hold the result of the op in s1 until it leaves
	always_comb begin
		res.segments         = sadc_pkg::seg_lookup(char_q[idx_s1]);
		res.dot_comma        = mark_q[idx_s1];
		res.brightness_level = bright_q;
		res.digit_count_out  = du_q;
		res.cursor           = wp_q;
		res.byte_done        = done_s1;
	end

`ifndef ASSERT_OFF
	a_du_range: assert property (@(posedge clk) disable iff (!arst_n)
		du_q != 5'd0 && du_q <= sadc_pkg::DIGITS_RESET)
		else $error("digit count out of range");

	a_lreset: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && op.code == sadc_pkg::OP_LRESET) |=>
		(bright_q == sadc_pkg::BRIGHT_RESET && wp_q == '0 && prev_q == '0))
		else $error("line reset did not restore settings");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && res_full) |=> (v_s1 && $stable(idx_s1) && $stable(wp_q) && $stable(du_q)))
		else $error("stalled result or state changed");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> (v_s1 && done_s1 == ($past(op.code) == sadc_pkg::OP_EXEC)))
		else $error("done flag does not follow executed op");
`endif

endmodule
